[hdl/sqp_pkg.sv]
// ----------------------------------------------------------------------------
// sqp_pkg
// Types, codes and sizing shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package sqp_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned KeyW  = 32;

  // operation codes; codes five to seven only report the head
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_PEEK   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]             op;
    logic signed [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [KeyW-1:0] result_key;
    logic [4:0]             count;
  } rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                   ins;
    logic                   del;
    logic                   clr;
    logic signed [KeyW-1:0] key;
  } cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic                   valid;
    logic                   le;     // valid and key <= request key
    logic                   eq;     // valid and key == request key
  } nb_t;

endpackage

[hdl/sqp_cell.sv]
// ----------------------------------------------------------------------------
// sqp_cell
// One slot of the sorted chain: holds a key, shifts right on insert and
// left on delete, deciding from its own compare and its neighbors'.
// ----------------------------------------------------------------------------
module sqp_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sqp_pkg::cmd_t cmd_i,
  input  sqp_pkg::nb_t  left_i,
  input  sqp_pkg::nb_t  right_i,
  output sqp_pkg::nb_t  nb_o
);
  import sqp_pkg::*;

  logic signed [KeyW-1:0] key_q, key_d;
  logic                   valid_q, valid_d;
  logic                   le, eq;

  assign le = valid_q && (key_q <= cmd_i.key);
  assign eq = valid_q && (key_q == cmd_i.key);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    priority if (cmd_i.clr) begin
      valid_d = 1'b0;
    end else if (cmd_i.ins) begin
      // keep anything not above the new key, else open a gap or shift right
      if (!le) begin
        if (left_i.le) begin
          key_d   = cmd_i.key;
          valid_d = 1'b1;
        end else if (left_i.valid) begin
          key_d   = left_i.key;
          valid_d = 1'b1;
        end
      end
    end else if (cmd_i.del) begin
      // entries at or above the key close up from the right
      if (valid_q && (!le || eq)) begin
        key_d   = right_i.key;
        valid_d = right_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign nb_o = '{key: key_q, valid: valid_q, le: le, eq: eq};

endmodule

[hdl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept as a chain of sorted cells; smallest key first.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   req     | in        | req_valid_i / req_ready_o | req_i  (op, key)
//   rsp     | out       | rsp_valid_o / rsp_ready_i | rsp_o  (status, key, count)
//
// For each request, every cell compares its key with the request
// key in the same cycle and shifts or holds, so the chain is updated at the
// accepting edge and one response per request lands in the response register.
// A new request is taken when no response is held or the held one is taken in the same cycle;
// a stalled response holds the request side until it drains.
// Reset empties the chain at once (cell valid bits and count clear).
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  sqp_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output sqp_pkg::rsp_t rsp_o
);
  import sqp_pkg::*;

  nb_t              nb [Depth];
  cmd_t             cmd;
  logic             acc;
  logic             found;
  logic             full;
  logic             empty;
  logic [CntW-1:0]  count_q, count_d;
  logic             rsp_valid_q;
  rsp_t             rsp_q, rsp_d;

  // one response per request: accept whenever the response slot frees up
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign acc         = req_valid_i && req_ready_o;

  assign full  = (count_q == CntW'(Depth));
  assign empty = (count_q == '0);

  // any held entry equal to the request key
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      found = found | nb[i].eq;
    end
  end

  // broadcast command; gate shifts so refused operations leave the chain alone
  always_comb begin
    cmd.key = req_i.key;
    cmd.ins = acc && (req_i.op == OP_INSERT) && !full;
    cmd.del = acc && (req_i.op == OP_DELETE) && found;
    cmd.clr = acc && (req_i.op == OP_CLEAR);
  end

  // the chain
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    nb_t left, right;
    if (g == 0) begin : g_first
      assign left = '{key: '0, valid: 1'b1, le: 1'b1, eq: 1'b0};
    end else begin : g_mid_l
      assign left = nb[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right = '{key: '0, valid: 1'b0, le: 1'b0, eq: 1'b0};
    end else begin : g_mid_r
      assign right = nb[g+1];
    end
    sqp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .nb_o    (nb[g])
    );
  end

  // count after the operation
  always_comb begin
    count_d = count_q;
    priority if (cmd.clr) begin
      count_d = '0;
    end else if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  // build the response from the state before the edge; the count is the one after the operation
  always_comb begin
    rsp_d.status     = ST_OK;
    rsp_d.result_key = '0;
    rsp_d.count      = 5'(count_d);
    unique case (req_i.op)
      OP_INSERT: begin
        if (full) begin
          rsp_d.status     = ST_FULL;
          rsp_d.result_key = nb[0].key;
        end else if (nb[0].le) begin
          rsp_d.result_key = nb[0].key;
        end else begin
          // new key becomes the head
          rsp_d.result_key = req_i.key;
        end
      end
      OP_DELETE, OP_FIND: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (!found) begin
          rsp_d.status = ST_NOT_FOUND;
        end else begin
          rsp_d.result_key = req_i.key;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          rsp_d.result_key = nb[0].key;
        end
      end
      OP_CLEAR: begin
        rsp_d.result_key = '0;
      end
      default: begin
        // unused codes report the head
        if (!empty) begin
          rsp_d.result_key = nb[0].key;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (acc) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // hold the response until it is taken
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
